/* design/mf_pkg.sv */
// Shared types, register indexes and compare helpers for the 3x3 median filter.
package mf_pkg;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam int CSR_DATA_WIDTH = 11;
   localparam int PIXEL_WIDTH    = 8;
   localparam int COORD_WIDTH    = 10;
   localparam int WINDOW_COLS    = 3;
   localparam logic [CSR_DATA_WIDTH-1:0] SIZE_RESET = 11'd1024;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;

   // Input request payload.
   typedef struct packed {
      pixel_type pixel;
      logic      frame_start;
   } req_type;

   // Result payload.
   typedef struct packed {
      pixel_type              median_value;
      logic [COORD_WIDTH-1:0] center_row;
      logic [COORD_WIDTH-1:0] center_col;
      logic                   frame_last;
   } rsp_type;

   // One window column, sorted from smallest to largest.
   typedef struct packed {
      pixel_type lo;
      pixel_type md;
      pixel_type hi;
   } column_type;

   // Per-request scan status produced by the position counters.
   typedef struct packed {
      logic                   emit;
      logic                   last;
      logic [COORD_WIDTH-1:0] center_row;
      logic [COORD_WIDTH-1:0] center_col;
   } scan_info_type;

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Three-input sorting network.
   function automatic column_type sort3(input pixel_type a, input pixel_type b,
                                        input pixel_type c);
      column_type s;
      s.lo = min2(min2(a, b), c);
      s.md = med3(a, b, c);
      s.hi = max2(max2(a, b), c);
      return s;
   endfunction

endpackage

/* design/mf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read-first data.
module mf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; a read and a write to the same address return the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mf_scan_ctrl.sv */
// Row and column counters, size clamping and border detection for the pixel scan.
module mf_scan_ctrl #(
   parameter int MAX_LINE_WIDTH   = 1024,
   parameter int MAX_FRAME_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              frame_start,
   input  logic [mf_pkg::CSR_DATA_WIDTH-1:0] line_width,
   input  logic [mf_pkg::CSR_DATA_WIDTH-1:0] frame_height,
   output logic [$clog2(MAX_LINE_WIDTH)-1:0] col_addr,
   output mf_pkg::scan_info_type             info
);
   import mf_pkg::*;

   localparam int CW = $clog2(MAX_LINE_WIDTH);
   localparam int RW = $clog2(MAX_FRAME_HEIGHT);

   logic [CW-1:0] col_ff, col_in, col_eff, w_last;
   logic [RW-1:0] row_ff, row_in, row_eff, h_last;

   // Last column and last row index after clamping the registers to 3..maximum.
   always_comb begin
      if (line_width < CSR_DATA_WIDTH'(3)) begin
         w_last = CW'(2);
      end else if (32'(line_width) > 32'(MAX_LINE_WIDTH)) begin
         w_last = CW'(MAX_LINE_WIDTH - 1);
      end else begin
         w_last = CW'(32'(line_width) - 32'd1);
      end
      if (frame_height < CSR_DATA_WIDTH'(3)) begin
         h_last = RW'(2);
      end else if (32'(frame_height) > 32'(MAX_FRAME_HEIGHT)) begin
         h_last = RW'(MAX_FRAME_HEIGHT - 1);
      end else begin
         h_last = RW'(32'(frame_height) - 32'd1);
      end
   end

   // Position of the current request; a frame start restarts the scan.
   assign col_eff  = frame_start ? '0 : col_ff;
   assign row_eff  = frame_start ? '0 : row_ff;
   assign col_addr = col_eff;

   // The window is complete and centered inside the frame.
   always_comb begin
      info.emit = (row_eff >= RW'(2)) && (col_eff >= CW'(2)) &&
                  (row_eff <= h_last) && (col_eff <= w_last);
      info.last = (row_eff == h_last) && (col_eff == w_last);
      info.center_row = COORD_WIDTH'(32'(row_eff) - 32'd1);
      info.center_col = COORD_WIDTH'(32'(col_eff) - 32'd1);
   end

   // Advance the scan, wrapping at the end of a row and of a frame.
   always_comb begin
      if (col_eff >= w_last) begin
         col_in = '0;
         row_in = (row_eff >= h_last) ? '0 : RW'(row_eff + RW'(1));
      end else begin
         col_in = CW'(col_eff + CW'(1));
         row_in = row_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

/* design/mf_column_cell.sv */
// One window column cell: holds a sorted column and passes it to the next cell.
module mf_column_cell (
   input  logic               clock,
   input  logic               shift,
   input  mf_pkg::column_type col_in,
   output mf_pkg::column_type col_out
);
   import mf_pkg::*;

   column_type col_ff;

   // Take the neighbor's column whenever the window moves by one pixel.
   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

/* design/median_filter_3x3.sv */
// Top level of the streaming 3x3 median filter.
//
// Pixels arrive in raster order on the req_ channel, one request per clock while
// the output is not stalled. A request with frame_start set is taken as row 0, column 0. The
// csr_ port sets line_width (index 0) and frame_height (index 1); write it only
// while no request is in flight. Every interior pixel yields one rsp_ result
// with the median of its nine neighbors, its row and column, and frame_last on
// the last interior pixel. Border pixels yield nothing.
// Throughput is one pixel per cycle while the receiver does not stall. A result is
// valid once the request that completes its window has passed the line store read,
// the sorted column cells, the column merge, then the output register with the final
// median. The two line stores share one RAM read and one RAM write per pixel, which
// sets the one-pixel-per-cycle figure.
// Reset clears the counters and the pipeline valid bits; the line stores are
// not cleared and hold whatever was last written to them.
// When the receiver holds rsp_ready low with a result pending, the whole
// pipeline freezes and req_ready drops in the same cycle.
module median_filter_3x3 #(
   parameter int MAX_LINE_WIDTH   = 1024,
   parameter int MAX_FRAME_HEIGHT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mf_pkg::req_type                    req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mf_pkg::rsp_type                    rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mf_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import mf_pkg::*;

   localparam int CW = $clog2(MAX_LINE_WIDTH);
   localparam int LW = 2 * PIXEL_WIDTH;

   // Configuration registers.
   logic [CSR_DATA_WIDTH-1:0] line_width_ff, frame_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= SIZE_RESET;
         frame_height_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_LINE_WIDTH) begin
            line_width_ff <= csr_data;
         end
         if (csr_index == CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_data;
         end
      end
   end

   // Pipeline flow control: every stage moves together when the output can load.
   logic rsp_valid_ff;
   logic advance, accept;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Scan position of the incoming request.
   logic [CW-1:0] scan_addr;
   scan_info_type scan_info;

   mf_scan_ctrl #(
      .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
      .MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_data.frame_start),
      .line_width  (line_width_ff),
      .frame_height(frame_height_ff),
      .col_addr    (scan_addr),
      .info        (scan_info)
   );

   // Stage 1: line store read in flight.
   logic          s1_valid_ff;
   pixel_type     s1_pixel_ff;
   logic [CW-1:0] s1_addr_ff;
   scan_info_type s1_info_ff;
   logic          s1_fwd_ff;
   logic [LW-1:0] s1_fwd_data_ff;
   logic [LW-1:0] ram_rd_data, ram_wr_data, line_word;
   logic          ram_wr_en, addr_hit;
   pixel_type     up_pixel, mid_pixel;

   // Both line stores live in one word: upper row in the high byte.
   assign ram_wr_en   = s1_valid_ff && advance;
   assign line_word   = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign up_pixel    = line_word[LW-1:PIXEL_WIDTH];
   assign mid_pixel   = line_word[PIXEL_WIDTH-1:0];
   assign ram_wr_data = {mid_pixel, s1_pixel_ff};

   mf_ram #(
      .WIDTH(LW),
      .DEPTH(MAX_LINE_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(s1_addr_ff),
      .wr_data(ram_wr_data),
      .rd_en  (accept),
      .rd_addr(scan_addr),
      .rd_data(ram_rd_data)
   );

   // A read that meets the write of the previous pixel takes the new word directly.
   assign addr_hit = s1_valid_ff && (s1_addr_ff == scan_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_data.pixel;
         s1_addr_ff     <= scan_addr;
         s1_info_ff     <= scan_info;
         s1_fwd_ff      <= addr_hit;
         s1_fwd_data_ff <= ram_wr_data;
      end
   end

   // Stage 2: chain of column cells; the newest sorted column enters cell 0.
   logic          cell_shift;
   column_type    cell_in  [WINDOW_COLS];
   column_type    cell_out [WINDOW_COLS];
   logic          s2_valid_ff;
   scan_info_type s2_info_ff;

   assign cell_shift = s1_valid_ff && advance;
   assign cell_in[0] = sort3(up_pixel, mid_pixel, s1_pixel_ff);

   for (genvar i = 0; i < WINDOW_COLS; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign cell_in[i] = cell_out[i-1];
      end
      mf_column_cell u_cell (
         .clock  (clock),
         .shift  (cell_shift),
         .col_in (cell_in[i]),
         .col_out(cell_out[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_shift) begin
         s2_info_ff <= s1_info_ff;
      end
   end

   // Stage 3: merge the sorted columns into three candidates for the median.
   logic          s3_valid_ff;
   scan_info_type s3_info_ff;
   pixel_type     s3_lo_ff, s3_md_ff, s3_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         s3_info_ff <= s2_info_ff;
         s3_lo_ff   <= max2(max2(cell_out[0].lo, cell_out[1].lo), cell_out[2].lo);
         s3_md_ff   <= med3(cell_out[0].md, cell_out[1].md, cell_out[2].md);
         s3_hi_ff   <= min2(min2(cell_out[0].hi, cell_out[1].hi), cell_out[2].hi);
      end
   end

   // Output register: only interior pixels produce a result.
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_in;

   assign rsp_valid_in = s3_valid_ff && s3_info_ff.emit;

   always_comb begin
      rsp_data_in.median_value = med3(s3_lo_ff, s3_md_ff, s3_hi_ff);
      rsp_data_in.center_row   = s3_info_ff.center_row;
      rsp_data_in.center_col   = s3_info_ff.center_col;
      rsp_data_in.frame_last   = s3_info_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A read colliding with the pending line store write must use the bypass.
   a_fwd_on_hit: assert property (@(posedge clock) disable iff (reset)
      accept && addr_hit |=> s1_fwd_ff)
      else $error("line store bypass not taken on address collision");

   // A new result always comes from an interior pixel leaving the merge stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff && s3_info_ff.emit))
      else $error("result appeared without an interior pixel behind it");

   // A stalled receiver freezes the pipeline behind the output register.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(s3_valid_ff) && $stable(s3_md_ff) &&
                                     $stable(s2_valid_ff) && $stable(s1_valid_ff))
      else $error("pipeline moved while the receiver stalled");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the 3x3 median filter, driven by raster pixel streams.
`timescale 1ns / 100ps

module testbench;
   import mf_pkg::*;

   localparam int unsigned MAX_LINE_WIDTH   = 1024;
   localparam int unsigned MAX_FRAME_HEIGHT = 1024;
   localparam int unsigned DRAIN_CYCLES     = 12;
   localparam int unsigned CYCLE_LIMIT      = 400000;

   typedef enum int {
      STYLE_UNIFORM,
      STYLE_FLAT,
      STYLE_BINARY,
      STYLE_GRADIENT
   } frame_style_type;

   // One pixel waiting to be sent; a held pixel waits for all results to drain.
   typedef struct {
      req_type req;
      bit      hold;
   } queued_pixel_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   queued_pixel_type pixel_queue[$];
   rsp_type          pending_medians[$];

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned items_queued       = 0;
   int unsigned pixels_accepted    = 0;
   int unsigned results_checked    = 0;
   int unsigned settings_count     = 0;
   int unsigned failures           = 0;
   int unsigned cycle_count        = 0;

   // Predictor state: register copies, both line stores, window and scan position.
   logic [CSR_DATA_WIDTH-1:0] width_reg  = SIZE_RESET;
   logic [CSR_DATA_WIDTH-1:0] height_reg = SIZE_RESET;
   pixel_type   upper_row [0:MAX_LINE_WIDTH-1];
   pixel_type   lower_row [0:MAX_LINE_WIDTH-1];
   pixel_type   window_px [0:2][0:2];
   int unsigned scan_col = 0;
   int unsigned scan_row = 0;

   median_filter_3x3 DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register values below three act as three, values above the maximum as the maximum.
   function automatic int unsigned clamp_dim(input logic [CSR_DATA_WIDTH-1:0] raw,
                                             input int unsigned limit);
      if (32'(raw) < 32'd3) return 3;
      if (32'(raw) > limit) return limit;
      return 32'(raw);
   endfunction

   // The fifth smallest of the nine window pixels: fewer than five below, five or more at or below.
   function automatic pixel_type window_median();
      pixel_type   taps [9];
      int unsigned below;
      int unsigned not_above;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            taps[r*3 + c] = window_px[r][c];
      for (int i = 0; i < 9; i++) begin
         below     = 0;
         not_above = 0;
         for (int j = 0; j < 9; j++) begin
            if (taps[j] < taps[i]) below++;
            if (taps[j] <= taps[i]) not_above++;
         end
         if (below <= 4 && not_above > 4) return taps[i];
      end
      return taps[0];
   endfunction

   // Moves the predictor by one accepted request and queues the result it causes, if any.
   function automatic void advance_window(input req_type px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      pixel_type   from_upper;
      pixel_type   from_lower;
      rsp_type     result;
      w = clamp_dim(width_reg, MAX_LINE_WIDTH);
      h = clamp_dim(height_reg, MAX_FRAME_HEIGHT);
      if (px.frame_start) begin
         scan_col = 0;
         scan_row = 0;
      end
      c = scan_col;
      r = scan_row;

      from_upper   = upper_row[c];
      from_lower   = lower_row[c];
      upper_row[c] = from_lower;
      lower_row[c] = px.pixel;

      // Shift the window one column; column two takes the newest column.
      for (int k = 0; k < 3; k++) begin
         window_px[k][0] = window_px[k][1];
         window_px[k][1] = window_px[k][2];
      end
      window_px[0][2] = from_upper;
      window_px[1][2] = from_lower;
      window_px[2][2] = px.pixel;

      if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
         result.median_value = window_median();
         result.center_row   = COORD_WIDTH'(r - 1);
         result.center_col   = COORD_WIDTH'(c - 1);
         result.frame_last   = (r == h - 1 && c == w - 1);
         pending_medians.push_back(result);
      end

      if (c >= w - 1) begin
         scan_col = 0;
         scan_row = (r >= h - 1) ? 0 : r + 1;
      end else begin
         scan_col = c + 1;
      end
   endfunction

   function automatic void queue_pixel(input pixel_type value, input bit start, input bit hold);
      queued_pixel_type item;
      item.req.pixel       = value;
      item.req.frame_start = start;
      item.hold            = hold;
      pixel_queue.push_back(item);
      items_queued++;
   endfunction

   // A run of random pixels that begins a new frame.
   function automatic void queue_run(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         queue_pixel(pixel_type'($urandom_range(255)), i == 0, 1'b0);
   endfunction

   // One frame with content of a random character: noise, near-flat, black and white, or ramps.
   function automatic void queue_frame(input int unsigned w, input int unsigned rows,
                                       input bit with_start);
      frame_style_type style;
      int unsigned     base;
      pixel_type       value;
      style = frame_style_type'($urandom_range(3));
      base  = $urandom_range(255);
      for (int unsigned y = 0; y < rows; y++) begin
         for (int unsigned x = 0; x < w; x++) begin
            case (style)
               STYLE_UNIFORM: value = pixel_type'($urandom_range(255));
               STYLE_FLAT:    value = pixel_type'(base + $urandom_range(3));
               STYLE_BINARY:  value = $urandom_range(1) ? 8'hFF : 8'h00;
               default: begin
                  value = pixel_type'(base + x*5 + y*11);
                  if ($urandom_range(7) == 0) value = $urandom_range(1) ? 8'hFF : 8'h00;
               end
            endcase
            queue_pixel(value, with_start && x == 0 && y == 0, 1'b0);
         end
      end
   endfunction

   // Mostly whole frames, some unaligned frames and short bursts with stray frame starts.
   function automatic void queue_random(input int unsigned w, input int unsigned rows,
                                        input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      bit          first;
      stop_at = items_queued + count;
      first   = 1'b1;
      while (items_queued < stop_at) begin
         pick  = first ? 0 : $urandom_range(9);
         first = 1'b0;
         if (pick < 7) begin
            queue_frame(w, rows, 1'b1);
         end else if (pick == 7) begin
            queue_frame(w, rows, 1'b0);
         end else begin
            repeat ($urandom_range(1, 2*w))
               queue_pixel(pixel_type'($urandom_range(255)), $urandom_range(11) == 0, 1'b0);
         end
      end
   endfunction

   // Wait until every request is taken and every result has come, then let the pipeline empty.
   task automatic settle();
      while (pixels_accepted != items_queued || pending_medians.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] reg_index,
                            input logic [CSR_DATA_WIDTH-1:0] reg_value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= reg_value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (reg_index)
         CSR_LINE_WIDTH:   width_reg  = reg_value;
         CSR_FRAME_HEIGHT: height_reg = reg_value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_WIDTH-1:0] width_value,
                            input logic [CSR_DATA_WIDTH-1:0] height_value,
                            input int unsigned idle_pct, input int unsigned stall_pct);
      settle();
      write_reg(CSR_LINE_WIDTH, width_value);
      write_reg(CSR_FRAME_HEIGHT, height_value);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      settings_count++;
   endtask

   // Request driver: loads the next queued pixel once the current one is taken.
   always @(posedge clock) begin : driver
      queued_pixel_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_window(req_data);
            pixels_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                !(pixel_queue[0].hold && pending_medians.size() != 0)) begin
               head = pixel_queue.pop_front();
               req_valid <= 1'b1;
               req_data  <= head.req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every result must match the oldest predicted one.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (pending_medians.size() == 0) begin
               failures++;
               if (failures <= 20)
                  $display("%0t: result with none expected: median %0d row %0d col %0d last %0b",
                           $realtime, rsp_data.median_value, rsp_data.center_row,
                           rsp_data.center_col, rsp_data.frame_last);
            end else begin
               want = pending_medians.pop_front();
               if (rsp_data.median_value !== want.median_value ||
                   rsp_data.center_row !== want.center_row ||
                   rsp_data.center_col !== want.center_col ||
                   rsp_data.frame_last !== want.frame_last) begin
                  failures++;
                  if (failures <= 20)
                     $display("%0t: expected median %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                              $realtime, want.median_value, want.center_row,
                              want.center_col, want.frame_last, rsp_data.median_value,
                              rsp_data.center_row, rsp_data.center_col, rsp_data.frame_last);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_medians.size());
         $display("median_filter_3x3: mismatch");
         $finish;
      end
   end

   // Stimulus sequence.
   initial begin : stimulus
      pixel_type mixed_values [9] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128,
                                      8'd7, 8'd200, 8'd3, 8'd100};
      for (int k = 0; k < 3; k++)
         for (int j = 0; j < 3; j++)
            window_px[k][j] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame with sizes written below range: all white, then a wrapped frame
      // without frame start that mixes both extremes, then a frame start cut short.
      configure(11'd0, 11'd0, 0, 0);
      for (int i = 0; i < 9; i++) queue_pixel(8'hFF, i == 0, 1'b0);
      for (int i = 0; i < 9; i++) queue_pixel(mixed_values[i], 1'b0, 1'b0);
      queue_pixel(8'h00, 1'b1, 1'b0);
      queue_pixel(8'h00, 1'b0, 1'b0);

      // Random frames; the first request restarts the frame in the middle of a row.
      configure(11'd8, 11'd6, 0, 0);
      queue_random(8, 6, 120);

      // Narrowest row with a busy sender; one request waits for every result first.
      configure(11'd3, 11'd5, 50, 0);
      queue_random(3, 5, 40);
      queue_pixel(pixel_type'($urandom_range(255)), 1'b1, 1'b1);
      queue_random(3, 5, 40);

      // Stalling receiver; end part way into row four at column eleven.
      configure(11'd16, 11'd6, 0, 50);
      queue_random(16, 6, 90);
      queue_run(4*16 + 12);

      // Shrink both sizes below the counters; the stream goes on without a frame start.
      configure(11'd4, 11'd3, 36, 36);
      queue_pixel(pixel_type'($urandom_range(255)), 1'b0, 1'b0);
      queue_frame(4, 3, 1'b0);
      queue_random(4, 3, 60);

      // Both sizes above range act as the maximum: part of the first row only,
      // so nothing comes out.
      configure(11'd2047, 11'd2047, 50, 0);
      queue_run(40);

      // Tallest frame with the narrowest row, written below range.
      configure(11'd1, 11'd1024, 0, 50);
      queue_run(60);
      queue_random(3, 4, 40);

      settle();
      $display("Sent %0d pixels and checked %0d medians across %0d size settings,",
               pixels_accepted, results_checked, settings_count);
      $display("from the 3x3 minimum to clamped oversize rows, with mid-frame shrinks and restarts.");
      if (failures == 0) begin
         $display("median_filter_3x3: match");
      end else begin
         $display("median_filter_3x3: mismatch");
      end
      $finish;
   end

endmodule
